// ----- rtl/prq_pkg.sv -----
// shared types and constants of the priority ordered run queue
package prq_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TASK_W   = 8;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  // request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PICK    = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_WALK,
    S_ENQ_PUT,
    S_DEQ_WALK,
    S_RESP
  } state_t;

  // one queue slot as stored in the slot memory
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  // outcome of the shared slot compare unit
  typedef struct packed {
    logic pri_above;
    logic id_match;
  } cmp_res_t;

endpackage

// ----- rtl/prq_if.sv -----
// request and result channel interfaces of the run queue
interface prq_in_if;
  import prq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [TASK_W-1:0] task_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, command, task_id, priority_req, input ready);
  modport sink (input valid, command, task_id, priority_req, output ready);
endinterface

interface prq_out_if;
  import prq_pkg::*;

  logic                valid;
  logic                ready;
  logic [TASK_W-1:0]   head_task;
  logic                head_valid;
  logic [COUNT_W-1:0]  entry_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, head_task, head_valid, entry_count, status, input ready);
  modport sink (input valid, head_task, head_valid, entry_count, status, output ready);
endinterface

// ----- rtl/prq_ram.sv -----
// generic simple dual port ram with registered read
module prq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/prq_cmp.sv -----
// shared compare unit applied to one slot per cycle during a walk
module prq_cmp (
  input  prq_pkg::slot_t    slot,
  input  prq_pkg::slot_t    req,
  output prq_pkg::cmp_res_t res
);
  import prq_pkg::*;

  // new task goes ahead of a slot of strictly lower priority
  assign res.pri_above = (req.prio > slot.prio);
  // dequeue looks for the named task
  assign res.id_match  = (req.task_id == slot.task_id);

endmodule

// ----- rtl/priority_ordered_run_queue.sv -----
// Run queue of task ids held in descending priority order, ties first-come first-served.
// The slots live in a one-write one-read RAM and a small sequencer walks them one slot per
// cycle through a single compare unit, so the block takes one request at a time and drops
// in_ch.ready until the result has been taken. Pick (and the unused code three) goes
// straight to the result, as do a refused enqueue into a full queue and a dequeue on an
// empty queue. Enqueue walks from the tail toward the head, moving each slot of lower
// priority one place back, then writes the new task into the slot it lands in; into an
// empty queue it writes the head slot at once. Dequeue walks from the head over every
// queued slot, closing the gap behind a match. The next request is taken in the cycle
// after the result leaves. The result holds the head task, the entry count and a status,
// and stays on out_ch until it is taken.
module priority_ordered_run_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  prq_in_if.sink    in_ch,
  prq_out_if.source out_ch
);
  import prq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              found_r, found_nxt;
  status_t           status_r, status_nxt;
  slot_t             req_r, req_nxt;
  logic [TASK_W-1:0] head_r, head_nxt;

  logic              in_fire;
  logic              q_full;
  logic              q_empty;
  logic              at_last;
  logic [CW+4:0]     occ_ext;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  slot_t             ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  slot_t             ram_rd_data;
  cmp_res_t          cmp_res;

  assign in_fire = in_ch.valid & in_ch.ready;
  assign q_full  = (occ_r == CW'(QUEUE_DEPTH));
  assign q_empty = (occ_r == '0);
  assign at_last = (CW'(idx_r) == (occ_r - CW'(1)));

  // slot storage
  prq_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // compare unit shared by both walks
  prq_cmp u_cmp (
    .slot (ram_rd_data),
    .req  (req_r),
    .res  (cmp_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.command)
            CMD_ENQUEUE: begin
              if (q_full) begin
                state_nxt = S_RESP;
              end else if (q_empty) begin
                state_nxt = S_ENQ_PUT;
              end else begin
                state_nxt = S_ENQ_WALK;
              end
            end
            CMD_DEQUEUE: begin
              state_nxt = q_empty ? S_RESP : S_DEQ_WALK;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_ENQ_WALK: begin
        if (!cmp_res.pri_above || (idx_r == '0)) begin
          state_nxt = S_ENQ_PUT;
        end
      end
      S_ENQ_PUT: begin
        state_nxt = S_RESP;
      end
      S_DEQ_WALK: begin
        if (at_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // handshake and memory controls
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = '0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = '0;
    ram_wr_data  = ram_rd_data;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        ram_rd_en   = 1'b1;
        // enqueue starts at the tail, dequeue at the head
        if (in_ch.command == CMD_ENQUEUE) begin
          ram_rd_addr = AW'(occ_r - CW'(1));
        end
      end
      S_ENQ_WALK: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_r - AW'(1);
        // slot of lower priority moves one place toward the tail
        if (cmp_res.pri_above) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = idx_r + AW'(1);
        end
      end
      S_ENQ_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r;
        ram_wr_data = req_r;
      end
      S_DEQ_WALK: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_r + AW'(1);
        // behind a match every slot moves one place toward the head
        if (found_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = idx_r - AW'(1);
        end
      end
      S_RESP: begin
        out_ch.valid = 1'b1;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // walk index, occupancy, status and request capture
  always_comb begin
    occ_nxt    = occ_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    req_nxt    = req_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt.task_id = in_ch.task_id;
          req_nxt.prio    = in_ch.priority_req;
          found_nxt       = 1'b0;
          status_nxt      = ST_OK;
          idx_nxt         = '0;
          case (in_ch.command)
            CMD_ENQUEUE: begin
              if (q_full) begin
                status_nxt = ST_FULL;
              end else if (!q_empty) begin
                idx_nxt = AW'(occ_r - CW'(1));
              end
            end
            CMD_DEQUEUE: begin
              if (q_empty) begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_ENQ_WALK: begin
        if (!cmp_res.pri_above) begin
          idx_nxt = idx_r + AW'(1);
        end else if (idx_r != '0) begin
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_ENQ_PUT: begin
        occ_nxt = occ_r + CW'(1);
      end
      S_DEQ_WALK: begin
        found_nxt = found_r | cmp_res.id_match;
        if (at_last) begin
          if (found_nxt) begin
            occ_nxt = occ_r - CW'(1);
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  // head copy follows every write to the first slot
  always_comb begin
    head_nxt = head_r;
    if (ram_wr_en && (ram_wr_addr == '0)) begin
      head_nxt = ram_wr_data.task_id;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      occ_r    <= '0;
      found_r  <= 1'b0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    req_r  <= req_nxt;
    head_r <= head_nxt;
  end

  // result fields
  assign occ_ext            = {5'd0, occ_r};
  assign out_ch.head_task   = q_empty ? '0 : head_r;
  assign out_ch.head_valid  = !q_empty;
  assign out_ch.entry_count = occ_ext[COUNT_W-1:0];
  assign out_ch.status      = status_r;

`ifndef SYNTHESIS
  // occupancy never passes the queue depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  // a request is never taken while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("request accepted while result pending");

  // an insert adds exactly one entry
  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ENQ_PUT |=> occ_r == $past(occ_r) + CW'(1))
    else $error("insert did not add one entry");

  // slot writes stay within the occupied range plus the new tail
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> CW'(ram_wr_addr) <= occ_r)
    else $error("slot write outside occupied range");
`endif

endmodule
